### src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers shared by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define AST_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define AST_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### src/tanp_pkg.sv
// ----------------------------------------------------------------------------
// tanp_pkg
// Shared constants, command/status types and helpers for the tile averager.
// ----------------------------------------------------------------------------
`default_nettype none

package tanp_pkg;

    localparam int PAL_DEPTH = 64;
    localparam int PAL_AW    = 6;
    localparam int LIM_W     = 7;
    localparam int MAX_PIX   = 4096;
    localparam int CNT_W     = 13;
    localparam int SUM_W     = 20;
    localparam int REM_W     = 12;
    localparam int STEP_W    = 5;
    localparam int DIST_W    = 18;
    localparam int COL_W     = 8;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic acc;
        logic pal_wr;
        logic div_init;
        logic div_step;
        logic search_init;
        logic issue;
        logic emit;
    } tanp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic div_last;
        logic search_more;
        logic pipe_busy;
    } tanp_stat_t;

    // One restoring division step: returns {new remainder, quotient bit}.
    function automatic logic [REM_W:0] div_step_f(input logic [REM_W-1:0] rem,
                                                   input logic msb,
                                                   input logic [CNT_W-1:0] dvs);
        logic [CNT_W-1:0] trial;
        logic [CNT_W-1:0] diff;
        trial = {rem, msb};
        diff  = trial - dvs;
        if (trial >= dvs)
        begin
            return {diff[REM_W-1:0], 1'b1};
        end
        return {trial[REM_W-1:0], 1'b0};
    endfunction

    function automatic logic [COL_W-1:0] abs_diff_f(input logic [COL_W-1:0] a,
                                                    input logic [COL_W-1:0] b);
        if (a >= b)
        begin
            return a - b;
        end
        return b - a;
    endfunction

endpackage

`default_nettype wire

### src/tanp_ctrl.sv
// ----------------------------------------------------------------------------
// tanp_ctrl
// Sequencer: accept, divide, palette search, drain and result emission.
// ----------------------------------------------------------------------------
`default_nettype none

module tanp_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic              action,
    input  wire logic              last_pixel,
    input  wire tanp_pkg::tanp_stat_t stat,
    output tanp_pkg::tanp_cmd_t    cmd,
    output logic                   busy
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_SEARCH,
        ST_DRAIN
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;

    always_comb
    begin
        state_next      = state_reg;
        cmd             = '0;
        cmd.acc         = accept && action;
        cmd.pal_wr      = accept && !action;
        cmd.div_init    = accept && action && last_pixel;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd.div_init)
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_last)
                begin
                    cmd.search_init = 1'b1;
                    state_next      = ST_SEARCH;
                end
            end
            ST_SEARCH:
            begin
                cmd.issue = stat.search_more;
                if (!stat.search_more)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!stat.pipe_busy)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

### src/tanp_datapath.sv
// ----------------------------------------------------------------------------
// tanp_datapath
// Accumulators, bit-serial dividers, palette memory and distance search.
// ----------------------------------------------------------------------------
`default_nettype none

module tanp_datapath (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire tanp_pkg::tanp_cmd_t       cmd,
    output tanp_pkg::tanp_stat_t           stat,
    input  wire logic                      cfg_we,
    input  wire logic [tanp_pkg::LIM_W-1:0] cfg_data,
    input  wire logic [tanp_pkg::COL_W-1:0] red,
    input  wire logic [tanp_pkg::COL_W-1:0] green,
    input  wire logic [tanp_pkg::COL_W-1:0] blue,
    input  wire logic [tanp_pkg::PAL_AW-1:0] entry_index,
    output logic                           done,
    output logic [tanp_pkg::PAL_AW-1:0]    match_index,
    output logic [tanp_pkg::COL_W-1:0]     avg_red,
    output logic [tanp_pkg::COL_W-1:0]     avg_green,
    output logic [tanp_pkg::COL_W-1:0]     avg_blue,
    output logic [tanp_pkg::DIST_W-1:0]    best_distance_sq,
    output logic                           no_match,
    output logic                           tile_overflow
);

    localparam int SUM_W  = tanp_pkg::SUM_W;
    localparam int CNT_W  = tanp_pkg::CNT_W;
    localparam int REM_W  = tanp_pkg::REM_W;
    localparam int COL_W  = tanp_pkg::COL_W;
    localparam int LIM_W  = tanp_pkg::LIM_W;
    localparam int PAL_AW = tanp_pkg::PAL_AW;
    localparam int DIST_W = tanp_pkg::DIST_W;
    localparam int STEP_W = tanp_pkg::STEP_W;

    logic [LIM_W-1:0]        pal_count_reg;
    logic [LIM_W-1:0]        limit;
    logic [SUM_W-1:0]        sum_r_reg, sum_g_reg, sum_b_reg;
    logic [CNT_W-1:0]        count_reg;
    logic                    ovf_reg;
    logic [REM_W-1:0]        rem_r_reg, rem_g_reg, rem_b_reg;
    logic [REM_W:0]          step_r, step_g, step_b;
    logic [STEP_W-1:0]       step_cnt_reg;
    logic [LIM_W-1:0]        addr_reg;
    logic [3*COL_W-1:0]      pal_mem [tanp_pkg::PAL_DEPTH];
    logic [3*COL_W-1:0]      rd_data_reg;
    logic [PAL_AW-1:0]       rd_idx_reg;
    logic                    rd_v_reg;
    logic [DIST_W-1:0]       dist_reg;
    logic [DIST_W-1:0]       dist_calc;
    logic [PAL_AW-1:0]       dist_idx_reg;
    logic                    dist_v_reg;
    logic                    found_reg;
    logic [DIST_W-1:0]       best_d_reg;
    logic [PAL_AW-1:0]       best_idx_reg;
    logic [COL_W-1:0]        dr, dg, db;
    logic [2*COL_W-1:0]      sq_r, sq_g, sq_b;
    logic                    take;

    // Counts above the memory depth are clamped.
    assign limit = (pal_count_reg > LIM_W'(tanp_pkg::PAL_DEPTH)) ?
                   LIM_W'(tanp_pkg::PAL_DEPTH) : pal_count_reg;

    assign stat.div_last    = (step_cnt_reg == STEP_W'(SUM_W - 1));
    assign stat.search_more = (addr_reg < limit);
    assign stat.pipe_busy   = rd_v_reg || dist_v_reg;

    assign step_r = tanp_pkg::div_step_f(rem_r_reg, sum_r_reg[SUM_W-1], count_reg);
    assign step_g = tanp_pkg::div_step_f(rem_g_reg, sum_g_reg[SUM_W-1], count_reg);
    assign step_b = tanp_pkg::div_step_f(rem_b_reg, sum_b_reg[SUM_W-1], count_reg);

    // After the divide the quotients sit in the low bits of the sum registers.
    assign dr = tanp_pkg::abs_diff_f(sum_r_reg[COL_W-1:0], rd_data_reg[3*COL_W-1:2*COL_W]);
    assign dg = tanp_pkg::abs_diff_f(sum_g_reg[COL_W-1:0], rd_data_reg[2*COL_W-1:COL_W]);
    assign db = tanp_pkg::abs_diff_f(sum_b_reg[COL_W-1:0], rd_data_reg[COL_W-1:0]);
    assign sq_r = {{COL_W{1'b0}}, dr} * {{COL_W{1'b0}}, dr};
    assign sq_g = {{COL_W{1'b0}}, dg} * {{COL_W{1'b0}}, dg};
    assign sq_b = {{COL_W{1'b0}}, db} * {{COL_W{1'b0}}, db};
    assign dist_calc = DIST_W'(sq_r) + DIST_W'(sq_g) + DIST_W'(sq_b);

    assign take = dist_v_reg && (!found_reg || (dist_reg < best_d_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pal_count_reg <= '0;
            sum_r_reg     <= '0;
            sum_g_reg     <= '0;
            sum_b_reg     <= '0;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            step_cnt_reg  <= '0;
            addr_reg      <= '0;
            rd_v_reg      <= 1'b0;
            dist_v_reg    <= 1'b0;
            found_reg     <= 1'b0;
            done          <= 1'b0;
        end
        else
        begin
            done       <= cmd.emit;
            rd_v_reg   <= cmd.issue;
            dist_v_reg <= rd_v_reg;
            if (cfg_we)
            begin
                pal_count_reg <= cfg_data;
            end
            if (cmd.acc)
            begin
                if (count_reg < CNT_W'(tanp_pkg::MAX_PIX))
                begin
                    sum_r_reg <= sum_r_reg + SUM_W'(red);
                    sum_g_reg <= sum_g_reg + SUM_W'(green);
                    sum_b_reg <= sum_b_reg + SUM_W'(blue);
                    count_reg <= count_reg + CNT_W'(1);
                end
                else
                begin
                    ovf_reg <= 1'b1;
                end
            end
            if (cmd.div_init)
            begin
                step_cnt_reg <= '0;
            end
            if (cmd.div_step)
            begin
                step_cnt_reg <= step_cnt_reg + STEP_W'(1);
                sum_r_reg    <= {sum_r_reg[SUM_W-2:0], step_r[0]};
                sum_g_reg    <= {sum_g_reg[SUM_W-2:0], step_g[0]};
                sum_b_reg    <= {sum_b_reg[SUM_W-2:0], step_b[0]};
            end
            if (cmd.search_init)
            begin
                addr_reg  <= '0;
                found_reg <= 1'b0;
            end
            if (cmd.issue)
            begin
                addr_reg <= addr_reg + LIM_W'(1);
            end
            if (take)
            begin
                found_reg <= 1'b1;
            end
            if (cmd.emit)
            begin
                sum_r_reg <= '0;
                sum_g_reg <= '0;
                sum_b_reg <= '0;
                count_reg <= '0;
                ovf_reg   <= 1'b0;
            end
        end
    end

    // Payload registers and palette memory.
    always_ff @(posedge clk)
    begin
        if (cmd.pal_wr)
        begin
            pal_mem[entry_index] <= {red, green, blue};
        end
        rd_data_reg  <= pal_mem[addr_reg[PAL_AW-1:0]];
        rd_idx_reg   <= addr_reg[PAL_AW-1:0];
        dist_reg     <= dist_calc;
        dist_idx_reg <= rd_idx_reg;
        if (cmd.div_init)
        begin
            rem_r_reg <= '0;
            rem_g_reg <= '0;
            rem_b_reg <= '0;
        end
        if (cmd.div_step)
        begin
            rem_r_reg <= step_r[REM_W:1];
            rem_g_reg <= step_g[REM_W:1];
            rem_b_reg <= step_b[REM_W:1];
        end
        if (cmd.search_init)
        begin
            best_d_reg   <= '0;
            best_idx_reg <= '0;
        end
        if (take)
        begin
            best_d_reg   <= dist_reg;
            best_idx_reg <= dist_idx_reg;
        end
        if (cmd.emit)
        begin
            match_index      <= best_idx_reg;
            avg_red          <= sum_r_reg[COL_W-1:0];
            avg_green        <= sum_g_reg[COL_W-1:0];
            avg_blue         <= sum_b_reg[COL_W-1:0];
            best_distance_sq <= best_d_reg;
            no_match         <= !found_reg;
            tile_overflow    <= ovf_reg;
        end
    end

endmodule

`default_nettype wire

### src/tile_average_nearest_palette_top.sv
// ----------------------------------------------------------------------------
// tile_average_nearest_palette_top
// Tile mean color and nearest palette entry search.
// ----------------------------------------------------------------------------
// Channel   Handshake            Payload
// input     start / busy         action, red, green, blue, entry_index, last_pixel
// result    done (one cycle)     match_index, avg_red/green/blue, best_distance_sq,
//                                no_match, tile_overflow
// config    cfg_we               cfg_data (palette count)
//
// Palette writes and pixels without the last mark leave busy low.
// A last pixel keeps busy high through bit-serial division by the pixel count, a
// search issuing one palette read for each of N entries, N being palette_count
// clamped to 64, then a drain of the read, distance and compare pipeline.
// done is high in the first cycle with busy low again. Reset is asynchronous and
// clears the sums, counts, flags and palette count; palette contents are undefined.
// The receiver cannot stall; each result is taken in its done cycle.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module tile_average_nearest_palette_top (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    output logic                            busy,
    input  wire logic                       action,
    input  wire logic [tanp_pkg::COL_W-1:0] red,
    input  wire logic [tanp_pkg::COL_W-1:0] green,
    input  wire logic [tanp_pkg::COL_W-1:0] blue,
    input  wire logic [tanp_pkg::PAL_AW-1:0] entry_index,
    input  wire logic                       last_pixel,
    input  wire logic                       cfg_we,
    input  wire logic [tanp_pkg::LIM_W-1:0] cfg_data,
    output logic                            done,
    output logic [tanp_pkg::PAL_AW-1:0]     match_index,
    output logic [tanp_pkg::COL_W-1:0]      avg_red,
    output logic [tanp_pkg::COL_W-1:0]      avg_green,
    output logic [tanp_pkg::COL_W-1:0]      avg_blue,
    output logic [tanp_pkg::DIST_W-1:0]     best_distance_sq,
    output logic                            no_match,
    output logic                            tile_overflow
);

    tanp_pkg::tanp_cmd_t  cmd;
    tanp_pkg::tanp_stat_t stat;

    tanp_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .action     (action),
        .last_pixel (last_pixel),
        .stat       (stat),
        .cmd        (cmd),
        .busy       (busy)
    );

    tanp_datapath u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .stat             (stat),
        .cfg_we           (cfg_we),
        .cfg_data         (cfg_data),
        .red              (red),
        .green            (green),
        .blue             (blue),
        .entry_index      (entry_index),
        .done             (done),
        .match_index      (match_index),
        .avg_red          (avg_red),
        .avg_green        (avg_green),
        .avg_blue         (avg_blue),
        .best_distance_sq (best_distance_sq),
        .no_match         (no_match),
        .tile_overflow    (tile_overflow)
    );

    // A result only follows a busy period, and a closing pixel starts one.
    `AST_SAME(a_done_after_busy, clk, rst_n, done, $past(busy))
    `AST_NEXT(a_last_goes_busy, clk, rst_n, start && !busy && action && last_pixel, busy)
    `AST_NEXT(a_done_single, clk, rst_n, done, !done)
    `AST_SAME(a_empty_result, clk, rst_n, done && no_match,
              (match_index == '0) && (best_distance_sq == '0))

endmodule

`default_nettype wire
